// File: design/joystick_dual_stepper_pulser_core_assert.svh
// Assertion macros shared by the checker of the stepper pulser core.
`ifndef JOYSTICK_DUAL_STEPPER_PULSER_CORE_ASSERT_SVH
`define JOYSTICK_DUAL_STEPPER_PULSER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define JDSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is checked in reset too.
`define JDSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/jdsp_pkg.sv
// Package with types and constants of the joystick dual stepper pulser.
package jdsp_pkg;

  localparam int RAW_W     = 12;
  localparam int PERIOD_W  = 11;
  localparam int WINDOW_W  = 16;
  localparam int SAMPLE_BITS_DEF = 12;

  // Division by 20 of a 12-bit magnitude: (n * 3277) >> 16 is exact up to 4095.
  localparam logic [11:0] DIV20_MUL   = 12'd3277;
  localparam int          DIV20_SHIFT = 16;
  // Division by 90 of an 18-bit magnitude: (n * 372828) >> 25 is exact below 381300.
  localparam logic [18:0] DIV90_MUL   = 19'd372828;
  localparam int          DIV90_SHIFT = 25;

  localparam logic [7:0] DEFLECT_MAX = 8'd100;
  localparam logic [6:0] DEADZONE    = 7'd10;

  localparam logic [RAW_W-1:0]    CENTER_RST = 12'd2048;
  localparam logic [PERIOD_W-1:0] SLOW_RST   = 11'd1562;
  localparam logic [PERIOD_W-1:0] FAST_RST   = 11'd156;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd50000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_SLOW       = 3'd2,
    REG_FAST       = 3'd3,
    REG_WINDOW     = 3'd4
  } cfg_reg_e;

  // Load enables of the three pipeline stages ahead of the output register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // What the item leaving stage three does to the axis state.
  typedef struct packed {
    logic sample;
    logic tick;
  } lane_ctl_t;

  // Axis values after the update, as they go into the result.
  typedef struct packed {
    logic                step;
    logic                dir;
    logic [PERIOD_W-1:0] period;
  } lane_res_t;

endpackage

// File: design/joystick_dual_stepper_pulser_core.sv
// Top level of the joystick driven two-axis stepper pulse generator.
//
// Input stream: each transfer carries one item; tuser is the command (sample or
// one-microsecond tick) and tdata the two converter readings. A sample sets
// direction and step period of both axes and restarts the step window; a tick
// inside the window counts both axes down and strobes an axis whose count runs out.
// Output stream: exactly one result per input item, in order, with step strobes,
// held directions and current periods (zero means stopped).
// Configuration: a write channel with register index and data, always ready;
// the user is to write registers only while no item is in flight; the block has no check.
// An item passes stages one to three and then the output register. The x and y
// lanes each run a three-stage pipeline (divide by 20 by reciprocal multiply,
// interpolation multiply, divide by 90 by reciprocal multiply); the axis state is
// updated as an item enters the output register. One item per cycle unless stalled.
// Reset clears the periods, countdowns, directions, window count and all valid
// bits, and loads the configuration defaults. When the receiver stalls, the
// result holds in the output register while empty stages keep taking items;
// input ready drops only once every stage is full.
module joystick_dual_stepper_pulser_core
  import jdsp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // x_raw[11:0], y_raw[23:12]
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // step_x, step_y, dir_x, dir_y, rate_x[14:4],
                                      // rate_y[25:15], zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SW = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam logic [RAW_W-1:0] SMASK = RAW_W'((32'd1 << SW) - 32'd1);

  logic [RAW_W-1:0]    center_x_q, center_y_q;
  logic [PERIOD_W-1:0] slow_q, fast_q;
  logic [WINDOW_W-1:0] window_q;
  logic [WINDOW_W-1:0] elapsed_q, elapsed_d;

  logic v1_q, v2_q, v3_q;
  logic cmd1_q, cmd2_q, cmd3_q;
  logic out_valid_q;
  logic [31:0] out_data_q;

  logic      en_out, move3;
  stage_en_t en;
  lane_ctl_t ctl;
  lane_res_t res_x, res_y;

  logic [RAW_W-1:0] x_raw, y_raw;

  assign x_raw = s_axis_tdata[11:0] & SMASK;
  assign y_raw = s_axis_tdata[23:12] & SMASK;

  // Each stage loads when it is empty or its item moves on.
  assign en_out = !out_valid_q || m_axis_tready;
  assign move3  = v3_q && en_out;
  assign en.s3  = !v3_q || en_out;
  assign en.s2  = !v2_q || en.s3;
  assign en.s1  = !v1_q || en.s2;
  assign s_axis_tready = en.s1;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_RST;
      center_y_q <= CENTER_RST;
      slow_q     <= SLOW_RST;
      fast_q     <= FAST_RST;
      window_q   <= WINDOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X: center_x_q <= cfg_data_i[RAW_W-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[RAW_W-1:0];
        REG_SLOW:     slow_q     <= cfg_data_i[PERIOD_W-1:0];
        REG_FAST:     fast_q     <= cfg_data_i[PERIOD_W-1:0];
        REG_WINDOW:   window_q   <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1)  v1_q <= s_axis_tvalid;
      if (en.s2)  v2_q <= v1_q;
      if (en.s3)  v3_q <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) cmd1_q <= s_axis_tuser;
    if (en.s2) cmd2_q <= cmd1_q;
    if (en.s3) cmd3_q <= cmd2_q;
  end

  // Window gating, shared by both lanes.
  always_comb begin
    ctl.sample = 1'b0;
    ctl.tick   = 1'b0;
    elapsed_d  = elapsed_q;
    if (move3) begin
      if (cmd3_q == CMD_SAMPLE) begin
        ctl.sample = 1'b1;
        elapsed_d  = '0;
      end else if (elapsed_q < window_q) begin
        ctl.tick  = 1'b1;
        elapsed_d = elapsed_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
    end else begin
      elapsed_q <= elapsed_d;
    end
  end

  jdsp_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .op_a_i (x_raw),
    .op_b_i (center_x_q),
    .slow_i (slow_q),
    .fast_i (fast_q),
    .ctl_i  (ctl),
    .res_o  (res_x)
  );

  // The y axis is inverted: center minus reading.
  jdsp_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .op_a_i (center_y_q),
    .op_b_i (y_raw),
    .slow_i (slow_q),
    .fast_i (fast_q),
    .ctl_i  (ctl),
    .res_o  (res_y)
  );

  // Merge both lanes into one result.
  always_ff @(posedge clk_i) begin
    if (move3) begin
      out_data_q <= {6'b0, res_y.period, res_x.period, res_y.dir, res_x.dir,
                     res_y.step, res_x.step};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: design/jdsp_lane.sv
// One axis lane: deflection, period interpolation and step countdown.
module jdsp_lane
  import jdsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stage_en_t           en_i,
  input  logic [RAW_W-1:0]    op_a_i,
  input  logic [RAW_W-1:0]    op_b_i,
  input  logic [PERIOD_W-1:0] slow_i,
  input  logic [PERIOD_W-1:0] fast_i,
  input  lane_ctl_t           ctl_i,
  output lane_res_t           res_o
);

  // Stage 1: offset magnitude divided by 20.
  logic signed [RAW_W:0]   off;
  logic        [RAW_W:0]   off_abs;
  logic        [23:0]      q20_prod;
  logic        [7:0]       q1_q;
  logic                    neg1_q;

  // Stage 2: clamp, deadzone and interpolation product.
  logic        [7:0]       mag;
  logic        [6:0]       t7;
  logic signed [11:0]      diff_s;
  logic signed [7:0]       t_s;
  logic signed [19:0]      prod_d;
  logic signed [19:0]      prod2_q;
  logic                    stop2_q;
  logic                    dir2_q;

  // Stage 3: product divided by 90, truncated toward zero.
  logic        [19:0]      prod_abs;
  logic        [36:0]      q90_prod;
  logic        [PERIOD_W-1:0] quot3_q;
  logic                    pneg3_q;
  logic                    stop3_q;
  logic                    dir3_q;

  // Final: period and axis state.
  logic        [PERIOD_W:0]   per_sum;
  logic        [PERIOD_W-1:0] per_new;
  logic        [PERIOD_W-1:0] period_q, period_d;
  logic        [PERIOD_W-1:0] count_q, count_d;
  logic                       dir_q, dir_d;
  logic                       step;

  assign off      = $signed({1'b0, op_a_i}) - $signed({1'b0, op_b_i});
  assign off_abs  = off[RAW_W] ? (~off + 1'b1) : off;
  assign q20_prod = 24'(off_abs[RAW_W-1:0]) * 24'(DIV20_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      q1_q   <= q20_prod[DIV20_SHIFT +: 8];
      neg1_q <= off[RAW_W];
    end
  end

  assign mag    = (q1_q > DEFLECT_MAX) ? DEFLECT_MAX : q1_q;
  assign t7     = mag[6:0] - DEADZONE;
  assign diff_s = $signed({1'b0, slow_i}) - $signed({1'b0, fast_i});
  assign t_s    = $signed({1'b0, t7});
  assign prod_d = diff_s * t_s;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod2_q <= prod_d;
      stop2_q <= (mag < 8'(DEADZONE));
      // A deflection that truncates to zero counts as positive.
      dir2_q  <= !neg1_q || (q1_q == 8'd0);
    end
  end

  assign prod_abs = prod2_q[19] ? 20'(-prod2_q) : 20'(prod2_q);
  assign q90_prod = 37'(prod_abs[17:0]) * 37'(DIV90_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      quot3_q <= q90_prod[DIV90_SHIFT +: PERIOD_W];
      pneg3_q <= prod2_q[19];
      stop3_q <= stop2_q;
      dir3_q  <= dir2_q;
    end
  end

  assign per_sum = pneg3_q ? ({1'b0, slow_i} + {1'b0, quot3_q})
                           : ({1'b0, slow_i} - {1'b0, quot3_q});
  assign per_new = stop3_q ? '0 : per_sum[PERIOD_W-1:0];

  always_comb begin
    period_d = period_q;
    count_d  = count_q;
    dir_d    = dir_q;
    step     = 1'b0;
    if (ctl_i.sample) begin
      period_d = per_new;
      count_d  = per_new;
      dir_d    = dir3_q;
    end else if (ctl_i.tick && (period_q != '0)) begin
      if (count_q <= PERIOD_W'(1)) begin
        count_d = period_q;
        step    = 1'b1;
      end else begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      count_q  <= '0;
      dir_q    <= 1'b0;
    end else begin
      period_q <= period_d;
      count_q  <= count_d;
      dir_q    <= dir_d;
    end
  end

  assign res_o.step   = step;
  assign res_o.dir    = dir_d;
  assign res_o.period = period_d;

endmodule

// File: design/jdsp_checker.sv
// Port-level checker of the stepper pulser core and its bind.
`include "joystick_dual_stepper_pulser_core_assert.svh"

module jdsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result stays put.
  `JDSP_ASSERT(a_out_hold,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
    "stalled result changed")

  // A strobe is only ever given on an axis that has a period.
  `JDSP_ASSERT(a_step_x_rate,
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[14:4] != 11'd0),
    "x step on a stopped axis")
  `JDSP_ASSERT(a_step_y_rate,
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[25:15] != 11'd0),
    "y step on a stopped axis")

  // With no result waiting, the pipeline can always take an item.
  `JDSP_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
    "input stalled with empty output")

  // No result comes out of reset.
  `JDSP_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_ni) |-> !m_axis_tvalid,
    "result valid at reset release")

endmodule

bind joystick_dual_stepper_pulser_core jdsp_checker u_jdsp_checker (.*);

// File: bench/joystick_dual_stepper_pulser_core_tb.sv
// Self-checking testbench for the joystick dual stepper pulser core.
module joystick_dual_stepper_pulser_core_tb;
  import jdsp_pkg::*;

  localparam int DEFL_DIV   = 20;
  localparam int RAMP_SPAN  = 90;
  localparam int PIPE_DEPTH = 4;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 165;

  // Result word as it sits in m_axis_tdata[25:0], step_x in bit 0.
  typedef struct packed {
    logic [PERIOD_W-1:0] rate_y;
    logic [PERIOD_W-1:0] rate_x;
    logic                dir_y;
    logic                dir_x;
    logic                step_y;
    logic                step_x;
  } step_out_t;

  typedef struct packed {
    logic                cmd;
    logic [RAW_W-1:0]    x_raw;
    logic [RAW_W-1:0]    y_raw;
    logic                typed;
    step_out_t           want;
  } stim_row_t;

  typedef struct packed {
    logic [RAW_W-1:0]    cx;
    logic [RAW_W-1:0]    cy;
    logic [PERIOD_W-1:0] slow;
    logic [PERIOD_W-1:0] fast;
    logic [WINDOW_W-1:0] win;
  } cfg_set_t;

  localparam step_out_t IDLE_OUT = '0;

  // Rows with want filled in are checked against that value; the others go
  // through the step-rate predictor. Defaults: center 2048, periods 1562/156.
  localparam int NUM_ROWS = 22;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{CMD_TICK,   12'd0,    12'd0,    1'b1, IDLE_OUT},
    '{CMD_TICK,   12'd4095, 12'd4095, 1'b1, IDLE_OUT},
    '{CMD_SAMPLE, 12'd2048, 12'd2048, 1'b1, '{11'd0,    11'd0,    1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_TICK,   12'd0,    12'd0,    1'b1, '{11'd0,    11'd0,    1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd4095, 12'd0,    1'b1, '{11'd156,  11'd156,  1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_TICK,   12'd1234, 12'd3210, 1'b0, IDLE_OUT},
    '{CMD_SAMPLE, 12'd0,    12'd4095, 1'b1, '{11'd156,  11'd156,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd2248, 12'd1848, 1'b1, '{11'd1562, 11'd1562, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd2247, 12'd1849, 1'b1, '{11'd0,    11'd0,    1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd2029, 12'd2067, 1'b1, '{11'd0,    11'd0,    1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd2028, 12'd2068, 1'b1, '{11'd0,    11'd0,    1'b0, 1'b0, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd1848, 12'd2248, 1'b1, '{11'd1562, 11'd1562, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd3148, 12'd1308, 1'b0, IDLE_OUT},
    '{CMD_TICK,   12'd4095, 12'd0,    1'b0, IDLE_OUT},
    '{CMD_TICK,   12'd0,    12'd4095, 1'b0, IDLE_OUT},
    '{CMD_TICK,   12'd2730, 12'd1365, 1'b0, IDLE_OUT},
    '{CMD_SAMPLE, 12'd2730, 12'd1365, 1'b0, IDLE_OUT},
    '{CMD_SAMPLE, 12'd1365, 12'd2730, 1'b0, IDLE_OUT},
    '{CMD_TICK,   12'd1365, 12'd2730, 1'b0, IDLE_OUT},
    '{CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1, '{11'd156,  11'd156,  1'b0, 1'b1, 1'b0, 1'b0}},
    '{CMD_SAMPLE, 12'd0,    12'd0,    1'b1, '{11'd156,  11'd156,  1'b1, 1'b0, 1'b0, 1'b0}},
    '{CMD_TICK,   12'd0,    12'd0,    1'b0, IDLE_OUT}
  };

  // Fixed settings for the first phases; the rest are drawn at random.
  localparam int NUM_FIXED = 5;
  localparam cfg_set_t FIXED_CFG [NUM_FIXED] = '{
    '{12'd2048, 12'd2048, 11'd20,   11'd2,    16'd60},
    '{12'd0,    12'd4095, 11'd2047, 11'd1,    16'd65535},
    '{12'd4095, 12'd0,    11'd1,    11'd2047, 16'd1},
    '{12'd2048, 12'd2048, 11'd0,    11'd25,   16'd40},
    '{12'd1000, 12'd3000, 11'd12,   11'd0,    16'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor copy of the registers and the axis state.
  logic [RAW_W-1:0]    ctr_x, ctr_y;
  logic [PERIOD_W-1:0] slow_p, fast_p;
  logic [WINDOW_W-1:0] win_len;
  logic [PERIOD_W-1:0] prd_x, prd_y, cnt_x, cnt_y;
  logic [WINDOW_W-1:0] ticks_done;
  logic                heading_x, heading_y;

  step_out_t expected_q [$];
  int        errors;
  int        src_idle_pct;
  int        snk_idle_pct;

  joystick_dual_stepper_pulser_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 500000);
    $display("joystick_dual_stepper_pulser_core: mismatch");
    $finish;
  end

  function automatic int deflection(input int offset);
    int v;
    v = offset / DEFL_DIV;
    if (v > int'(DEFLECT_MAX)) v = int'(DEFLECT_MAX);
    if (v < -int'(DEFLECT_MAX)) v = -int'(DEFLECT_MAX);
    return v;
  endfunction

  function automatic logic [PERIOD_W-1:0] ramp_period(input int mag);
    int p;
    if (mag < int'(DEADZONE)) return '0;
    p = int'(slow_p) - ((int'(slow_p) - int'(fast_p)) * (mag - int'(DEADZONE))) / RAMP_SPAN;
    return p[PERIOD_W-1:0];
  endfunction

  function automatic logic axis_fire(input logic [PERIOD_W-1:0] period,
                                     inout logic [PERIOD_W-1:0] cnt);
    if (period == '0) return 1'b0;
    if (cnt <= 1) begin
      cnt = period;
      return 1'b1;
    end
    cnt = cnt - 1'b1;
    return 1'b0;
  endfunction

  // Advances the axis state by one item and returns the result it produces.
  function automatic step_out_t predict_step(input logic cmd, input logic [RAW_W-1:0] xr,
                                             input logic [RAW_W-1:0] yr);
    step_out_t r;
    int dx, dy;
    r = '0;
    if (cmd == CMD_SAMPLE) begin
      dx = deflection(int'(xr) - int'(ctr_x));
      dy = deflection(int'(ctr_y) - int'(yr));
      heading_x  = (dx >= 0);
      heading_y  = (dy >= 0);
      prd_x      = ramp_period(dx < 0 ? -dx : dx);
      prd_y      = ramp_period(dy < 0 ? -dy : dy);
      cnt_x      = prd_x;
      cnt_y      = prd_y;
      ticks_done = '0;
    end else if (ticks_done < win_len) begin
      ticks_done = ticks_done + 1'b1;
      r.step_x   = axis_fire(prd_x, cnt_x);
      r.step_y   = axis_fire(prd_y, cnt_y);
    end
    r.dir_x  = heading_x;
    r.dir_y  = heading_y;
    r.rate_x = prd_x;
    r.rate_y = prd_y;
    return r;
  endfunction

  // Reading spread over the deadzone edge, the full range and the rails.
  function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] ctr);
    int v, off;
    off = 0;
    case ($urandom_range(3))
      0: v = $urandom_range(4095);
      1: off = $urandom_range(2100);
      2: off = $urandom_range(170, 230);
      default: v = $urandom_range(1) ? 4095 : 0;
    endcase
    if (off != 0) v = $urandom_range(1) ? int'(ctr) + off : int'(ctr) - off;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  task automatic drive_item(input logic cmd, input logic [RAW_W-1:0] xr,
                            input logic [RAW_W-1:0] yr, input logic typed,
                            input step_out_t want);
    step_out_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {yr, xr};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_step(cmd, xr, yr);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last register.
  task automatic cfg_send(input cfg_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CENTER_X: ctr_x   = data[RAW_W-1:0];
      REG_CENTER_Y: ctr_y   = data[RAW_W-1:0];
      REG_SLOW:     slow_p  = data[PERIOD_W-1:0];
      REG_FAST:     fast_p  = data[PERIOD_W-1:0];
      REG_WINDOW:   win_len = data;
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise in the random phases.
  task automatic apply_config(input cfg_set_t c, input logic noisy);
    logic [15:0] pad;
    pad = noisy ? 16'($urandom) : 16'd0;
    cfg_send(REG_CENTER_X, {pad[15:RAW_W], c.cx});
    cfg_send(REG_CENTER_Y, {pad[15:RAW_W], c.cy});
    cfg_send(REG_SLOW, {pad[15:PERIOD_W], c.slow});
    cfg_send(REG_FAST, {pad[15:PERIOD_W], c.fast});
    cfg_send(REG_WINDOW, c.win);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: random stalls, and every result transfer is checked in order.
  initial begin
    step_out_t got, want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(step_out_t)-1:0];
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with none expected", $time, got);
        end else begin
          want = expected_q.pop_front();
          report_field("step_x", want.step_x, got.step_x);
          report_field("step_y", want.step_y, got.step_y);
          report_field("dir_x", want.dir_x, got.dir_x);
          report_field("dir_y", want.dir_y, got.dir_y);
          report_field("rate_x", want.rate_x, got.rate_x);
          report_field("rate_y", want.rate_y, got.rate_y);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    cfg_set_t cs;
    int sample_pct;
    logic cmd;
    logic [RAW_W-1:0] xr, yr;

    errors        = 0;
    src_idle_pct  = 12;
    snk_idle_pct  = 50;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_CENTER_X;
    cfg_data_i    = '0;
    ctr_x      = CENTER_RST;
    ctr_y      = CENTER_RST;
    slow_p     = SLOW_RST;
    fast_p     = FAST_RST;
    win_len    = WINDOW_RST;
    prd_x      = '0;
    prd_y      = '0;
    cnt_x      = '0;
    cnt_y      = '0;
    ticks_done = '0;
    heading_x  = 1'b0;
    heading_y  = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      drive_item(DIRECTED[i].cmd, DIRECTED[i].x_raw, DIRECTED[i].y_raw,
                 DIRECTED[i].typed, DIRECTED[i].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain_results();
      if (ph <= 3) begin
        src_idle_pct = 12;
        snk_idle_pct = 50;
      end else if (ph <= 7) begin
        src_idle_pct = 50;
        snk_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (ph <= NUM_FIXED) begin
        apply_config(FIXED_CFG[ph-1], 1'b0);
      end else begin
        cs.cx   = $urandom_range(4095);
        cs.cy   = $urandom_range(4095);
        cs.slow = $urandom_range(1, 40);
        cs.fast = $urandom_range(1, 40);
        cs.win  = $urandom_range(1, 150);
        apply_config(cs, 1'b1);
      end
      // A low sample rate lets windows run out; a high one keeps restarting them.
      sample_pct = $urandom_range(3, 25);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(99) < sample_pct) ? CMD_SAMPLE : CMD_TICK;
        if (cmd == CMD_SAMPLE || n == 0) begin
          cmd = CMD_SAMPLE;
          xr  = pick_raw(ctr_x);
          yr  = pick_raw(ctr_y);
        end else begin
          xr = 12'($urandom);
          yr = 12'($urandom);
        end
        drive_item(cmd, xr, yr, 1'b0, IDLE_OUT);
      end
      s_axis_tvalid <= 1'b0;
    end

    drain_results();
    if (errors == 0) begin
      $display("joystick_dual_stepper_pulser_core: match");
    end else begin
      $display("joystick_dual_stepper_pulser_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/jdsp_pkg.sv
design/jdsp_lane.sv
design/joystick_dual_stepper_pulser_core.sv
design/jdsp_checker.sv
bench/joystick_dual_stepper_pulser_core_tb.sv
